// ===== src/vdist_pkg.sv =====
// ----------------------------------------------------------------------------
// vdist_pkg: shared types and constants for the vector distance unit
// Widths, saturation limits, metric codes and the queue entry format.
// ----------------------------------------------------------------------------
package vdist_pkg;

	localparam int COMP_W = 16;  // Q8.8 component
	localparam int MAG_W  = 16;  // |a - b|
	localparam int TERM_W = 32;  // squared magnitude
	localparam int SUM_W  = 42;  // accumulator
	localparam int DIST_W = 26;  // result distance
	localparam int ROOT_W = 21;  // floor sqrt of a 42-bit value
	localparam int REM_W  = 24;  // sqrt partial remainder

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;

	localparam logic [SUM_W-1:0] L1_LIMIT = (SUM_W'(1) << DIST_W) - SUM_W'(1);
	localparam logic [SUM_W-1:0] L2_LIMIT = {SUM_W{1'b1}};

	// metric codes
	localparam logic MODE_L1 = 1'b0;
	localparam logic MODE_L2 = 1'b1;

	// finished vector handed from the accumulator to the result stage
	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic             sat;
		logic             mode;
	} vec_entry_t;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ===== src/vdist_front.sv =====
// ----------------------------------------------------------------------------
// vdist_front: item intake and accumulation
// Two-stage term pipeline (|a-b|, then square or pass) feeding a saturating
// 42-bit accumulator; a finished vector is pushed into the queue.
// ----------------------------------------------------------------------------
module vdist_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          mode,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [vdist_pkg::COMP_W-1:0]  comp_a,
	input  logic [vdist_pkg::COMP_W-1:0]  comp_b,
	input  logic                          last,
	input  vdist_pkg::q_stat_t            q_stat,
	output logic                          push,
	output vdist_pkg::vec_entry_t         push_entry
);

	logic                          vld_s1, vld_s2;
	logic                          last_s1, last_s2;
	logic                          mode_s1, mode_s2;
	logic [vdist_pkg::MAG_W-1:0]   mag_s1;
	logic [vdist_pkg::TERM_W-1:0]  term_s2;
	logic [vdist_pkg::SUM_W-1:0]   acc_q;
	logic                          ovf_q;

	logic                          adv;
	logic signed [vdist_pkg::COMP_W:0] diff;
	logic [vdist_pkg::COMP_W:0]    diff_abs;
	logic [vdist_pkg::SUM_W:0]     sum_wide;
	logic [vdist_pkg::SUM_W-1:0]   lim;
	logic                          over;
	logic [vdist_pkg::SUM_W-1:0]   sum_new;
	logic                          ovf_new;

	// whole front moves together; it holds only when the queue is full
	assign adv      = !q_stat.full;
	assign in_ready = adv;

	// absolute difference
	always_comb begin
		diff     = $signed({comp_a[vdist_pkg::COMP_W-1], comp_a})
		         - $signed({comp_b[vdist_pkg::COMP_W-1], comp_b});
		diff_abs = diff[vdist_pkg::COMP_W] ? ((vdist_pkg::COMP_W+1)'(0) - diff) : diff;
	end

	// saturating accumulate of the stage-2 term
	always_comb begin
		sum_wide = {1'b0, acc_q} + (vdist_pkg::SUM_W+1)'(term_s2);
		lim      = (mode_s2 == vdist_pkg::MODE_L1) ? vdist_pkg::L1_LIMIT : vdist_pkg::L2_LIMIT;
		over     = sum_wide > {1'b0, lim};
		sum_new  = over ? lim : sum_wide[vdist_pkg::SUM_W-1:0];
		ovf_new  = ovf_q | over;
	end

	assign push            = adv && vld_s2 && last_s2;
	assign push_entry.sum  = sum_new;
	assign push_entry.sat  = ovf_new;
	assign push_entry.mode = mode_s2;

	// pipeline control and accumulator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			acc_q  <= '0;
			ovf_q  <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			if (vld_s2) begin
				if (last_s2) begin
					acc_q <= '0;
					ovf_q <= 1'b0;
				end else begin
					acc_q <= sum_new;
					ovf_q <= ovf_new;
				end
			end
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s1  <= diff_abs[vdist_pkg::MAG_W-1:0];
			last_s1 <= last;
			mode_s1 <= mode;
			last_s2 <= last_s1;
			mode_s2 <= mode_s1;
			if (mode_s1 == vdist_pkg::MODE_L1)
				term_s2 <= vdist_pkg::TERM_W'(mag_s1);
			else
				term_s2 <= mag_s1 * mag_s1;
		end
	end

endmodule

// ===== src/vdist_queue.sv =====
// ----------------------------------------------------------------------------
// vdist_queue: short queue of finished vectors
// Decouples the accumulator from the result stage; head is read directly.
// ----------------------------------------------------------------------------
module vdist_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  vdist_pkg::vec_entry_t push_entry,
	input  logic                  pop,
	output vdist_pkg::vec_entry_t head,
	output vdist_pkg::q_stat_t    stat
);

	vdist_pkg::vec_entry_t         mem [vdist_pkg::Q_DEPTH];
	logic [vdist_pkg::Q_AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [vdist_pkg::Q_AW:0]      cnt_q;

	assign head       = mem[rd_ptr_q];
	assign stat.full  = cnt_q == (vdist_pkg::Q_AW+1)'(vdist_pkg::Q_DEPTH);
	assign stat.empty = cnt_q == '0;

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= push_entry;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== src/vdist_back.sv =====
// ----------------------------------------------------------------------------
// vdist_back: result stage
// Takes a finished vector, clamps it (L1) or takes its floor square root
// two bits per cycle (L2), and holds the result in the output register.
// ----------------------------------------------------------------------------
module vdist_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  vdist_pkg::vec_entry_t         head,
	input  vdist_pkg::q_stat_t            q_stat,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [vdist_pkg::DIST_W-1:0]  out_dist,
	output logic                          out_sat
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROOT,
		ST_DONE
	} state_t;

	localparam logic [4:0] LAST_STEP = 5'(vdist_pkg::ROOT_W - 1);

	state_t                         state_q;
	logic [4:0]                     step_q;
	logic [vdist_pkg::SUM_W-1:0]    x_q;
	logic [vdist_pkg::REM_W-1:0]    rem_q;
	logic [vdist_pkg::ROOT_W-1:0]   root_q;
	logic [vdist_pkg::DIST_W-1:0]   res_q;
	logic                           sat_q;
	logic                           out_valid_q;
	logic [vdist_pkg::DIST_W-1:0]   out_dist_q;
	logic                           out_sat_q;

	logic [vdist_pkg::REM_W-1:0]    rem_sh;
	logic [vdist_pkg::REM_W-1:0]    trial;
	logic                           fits;
	logic                           out_free;

	assign out_valid = out_valid_q;
	assign out_dist  = out_dist_q;
	assign out_sat   = out_sat_q;
	assign out_free  = !out_valid_q || out_ready;
	assign pop       = (state_q == ST_IDLE) && !q_stat.empty;

	// one restoring square-root step
	always_comb begin
		rem_sh = {rem_q[vdist_pkg::REM_W-3:0], x_q[vdist_pkg::SUM_W-1 -: 2]};
		trial  = {1'b0, root_q, 2'b01};
		fits   = rem_sh >= trial;
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			x_q         <= '0;
			rem_q       <= '0;
			root_q      <= '0;
			res_q       <= '0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_dist_q  <= '0;
			out_sat_q   <= 1'b0;
		end else begin
			// valid rises when a result is loaded, falls once it is taken
			if ((state_q == ST_DONE) && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (!q_stat.empty) begin
						if (head.mode == vdist_pkg::MODE_L1) begin
							if (head.sum > vdist_pkg::L1_LIMIT) begin
								res_q <= vdist_pkg::L1_LIMIT[vdist_pkg::DIST_W-1:0];
								sat_q <= 1'b1;
							end else begin
								res_q <= head.sum[vdist_pkg::DIST_W-1:0];
								sat_q <= head.sat;
							end
							state_q <= ST_DONE;
						end else begin
							sat_q   <= head.sat;
							x_q     <= head.sum;
							rem_q   <= '0;
							root_q  <= '0;
							step_q  <= '0;
							state_q <= ST_ROOT;
						end
					end
				end
				ST_ROOT: begin
					x_q    <= x_q << 2;
					rem_q  <= fits ? (rem_sh - trial) : rem_sh;
					root_q <= {root_q[vdist_pkg::ROOT_W-2:0], fits};
					step_q <= step_q + 5'd1;
					if (step_q == LAST_STEP) begin
						res_q   <= vdist_pkg::DIST_W'({root_q[vdist_pkg::ROOT_W-2:0], fits});
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_dist_q  <= res_q;
						out_sat_q   <= sat_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== src/vector_distance_l1_l2_unit.sv =====
// ----------------------------------------------------------------------------
// vector_distance_l1_l2_unit: streaming L1 / Euclidean L2 vector distance
// Accumulates |a-b| or (a-b)^2 per item and emits one distance per vector.
// ----------------------------------------------------------------------------
//  channel   dir  width  contents
//  s_axis    in   32+1   component_a, component_b, last_element on tlast
//  m_axis    out  32+1   distance; saturated on tuser
//  cfg       in   1      metric_mode (0 = L1, 1 = L2), reset 1
//
//  Items are taken one per cycle while the queue is not full; each passes
//  two term stages before the accumulator. A finished vector goes to a
//  4-entry queue; L1 is clamped, L2 takes 21 root steps of 2 bits each.
//  s_axis_tready drops only while the queue is full. Reset is asynchronous.
// ----------------------------------------------------------------------------
module vector_distance_l1_l2_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [15:0] component_a, [31:16] component_b
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [25:0] distance, rest zero
	output logic        m_axis_tuser,   // [0] saturated
	input  logic        cfg_we,
	input  logic        cfg_wdata
);

	logic                          mode_q;
	logic                          push, pop;
	vdist_pkg::vec_entry_t         push_entry, head;
	vdist_pkg::q_stat_t            q_stat;
	logic [vdist_pkg::DIST_W-1:0]  dist_val;

	// metric register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mode_q <= vdist_pkg::MODE_L2;
		else if (cfg_we)
			mode_q <= cfg_wdata;
	end

	vdist_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode       (mode_q),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.comp_a     (s_axis_tdata[15:0]),
		.comp_b     (s_axis_tdata[31:16]),
		.last       (s_axis_tlast),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	vdist_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.stat       (q_stat)
	);

	vdist_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_dist  (dist_val),
		.out_sat   (m_axis_tuser)
	);

	assign m_axis_tdata = {{(32 - vdist_pkg::DIST_W){1'b0}}, dist_val};

	// checks
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("push into full queue");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from empty queue");

	a_stall_only_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> q_stat.full)
		else $error("input stalled without a full queue");

endmodule
